// ===== sv/btm_pkg.sv =====
// ----------------------------------------------------------------------------
// btm_pkg
// Shared types, sizes and codes for the tape machine step block.
// ----------------------------------------------------------------------------
package btm_pkg;

  localparam int PROG_DEPTH = 4096;
  localparam int TAPE_DEPTH = 65536;

  localparam int PA_W = $clog2(PROG_DEPTH);      // program address
  localparam int PL_W = $clog2(PROG_DEPTH + 1);  // program length / counter
  localparam int TA_W = $clog2(TAPE_DEPTH);      // tape address

  localparam logic [PL_W-1:0] PROG_FULL = PL_W'(PROG_DEPTH);
  localparam logic [TA_W-1:0] TAPE_LAST = TA_W'(TAPE_DEPTH - 1);

  // Command bytes
  localparam logic [7:0] CMD_RIGHT = 8'h3E;
  localparam logic [7:0] CMD_LEFT  = 8'h3C;
  localparam logic [7:0] CMD_INC   = 8'h2B;
  localparam logic [7:0] CMD_DEC   = 8'h2D;
  localparam logic [7:0] CMD_OUT   = 8'h2E;
  localparam logic [7:0] CMD_IN    = 8'h2C;
  localparam logic [7:0] CMD_OPEN  = 8'h5B;
  localparam logic [7:0] CMD_CLOSE = 8'h5D;
  localparam logic [7:0] CMD_END   = 8'h00;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  localparam logic [1:0] STATUS_RUN   = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [7:0] program_byte;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       took_input;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic            we;
    logic [PA_W-1:0] waddr;
    logic [7:0]      wdata;
    logic            re;
    logic [PA_W-1:0] raddr;
  } prog_req_t;

  typedef struct packed {
    logic            we;
    logic [TA_W-1:0] waddr;
    logic [7:0]      wdata;
    logic            re;
    logic [TA_W-1:0] raddr;
  } tape_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FSCAN_REQ,
    ST_FSCAN_CHK,
    ST_BSCAN_REQ,
    ST_BSCAN_CHK,
    ST_DONE
  } state_t;

endpackage

// ===== sv/bracket_tape_machine_step.sv =====
// ----------------------------------------------------------------------------
// bracket_tape_machine_step
// Interpreter for the eight-command tape language, one command per step.
// ----------------------------------------------------------------------------
// Input channel item_valid / item_ready / item: a load transfer appends
// item.program_byte to the program if it is not full and rewinds execution;
// a step transfer executes one program command against the byte tape.
// Output channel result_valid / result_ready / result: exactly one result per
// input transfer, in order.
// The program and the tape each live in a synchronous RAM with a registered
// read port; a step is a read of both, then a write-back of the tape cell.
// Items are handled one at a time. A load passes ST_IDLE and ST_DONE, a plain
// command ST_IDLE, ST_EXEC and ST_DONE; a skipped bracket adds a scan request
// and a scan check state per program byte scanned, since the scan reads the
// program RAM one byte per round trip. The result goes from ST_DONE into the
// output register. After reset the tape RAM is cleared one cell per cycle,
// all TAPE_DEPTH (65536) cells, with item_ready low. The program store is not
// cleared. A result waiting in the output register does not block the next
// transfer: the next item is taken and worked on, and its result is held back
// until the receiver takes the waiting one.
// ----------------------------------------------------------------------------
module bracket_tape_machine_step
  import btm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  prog_req_t  prog_req;
  tape_req_t  tape_req;
  logic [7:0] prog_rdata;
  logic [7:0] tape_rdata;
  logic       seq_valid;
  logic       seq_ready;
  result_t    seq_res;

  btm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (seq_valid),
    .res_ready  (seq_ready),
    .res        (seq_res),
    .prog_req   (prog_req),
    .prog_rdata (prog_rdata),
    .tape_req   (tape_req),
    .tape_rdata (tape_rdata)
  );

  btm_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog_ram (
    .clk   (clk),
    .we    (prog_req.we),
    .waddr (prog_req.waddr),
    .wdata (prog_req.wdata),
    .re    (prog_req.re),
    .raddr (prog_req.raddr),
    .rdata (prog_rdata)
  );

  btm_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape_ram (
    .clk   (clk),
    .we    (tape_req.we),
    .waddr (tape_req.waddr),
    .wdata (tape_req.wdata),
    .re    (tape_req.re),
    .raddr (tape_req.raddr),
    .rdata (tape_rdata)
  );

  // Output register: load when empty or being drained
  assign seq_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (seq_valid && seq_ready) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_valid && seq_ready) begin
      result <= seq_res;
    end
  end

endmodule

// ===== sv/btm_ram.sv =====
// ----------------------------------------------------------------------------
// btm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module btm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/btm_seq.sv =====
// ----------------------------------------------------------------------------
// btm_seq
// Sequencer: loads program bytes, executes one command per step item with a
// read-modify-write of the tape, and scans the program for matching brackets.
// ----------------------------------------------------------------------------
module btm_seq
  import btm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  item_t           item,
  output logic            res_valid,
  input  logic            res_ready,
  output result_t         res,
  output prog_req_t       prog_req,
  input  logic [7:0]      prog_rdata,
  output tape_req_t       tape_req,
  input  logic [7:0]      tape_rdata
);

  state_t          state, state_next;
  logic [PL_W-1:0] plen, plen_next;
  logic [PL_W-1:0] pc, pc_next;
  logic [TA_W-1:0] tp, tp_next;
  logic [1:0]      halt, halt_next;
  logic [PL_W-1:0] scan_p, scan_p_next;
  logic [PL_W-1:0] depth, depth_next;
  logic [TA_W-1:0] clr_addr, clr_addr_next;
  logic [7:0]      in_byte, in_byte_next;
  result_t         res_q, res_q_next;

  logic [PL_W-1:0] fdepth;
  logic [PL_W-1:0] bdepth;
  logic [PL_W-1:0] scan_prev;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      plen     <= '0;
      pc       <= '0;
      tp       <= '0;
      halt     <= STATUS_RUN;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      plen     <= plen_next;
      pc       <= pc_next;
      tp       <= tp_next;
      halt     <= halt_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_p  <= scan_p_next;
    depth   <= depth_next;
    in_byte <= in_byte_next;
    res_q   <= res_q_next;
  end

  // Depth after the byte just read during a scan
  always_comb begin
    fdepth = depth;
    bdepth = depth;
    if (prog_rdata == CMD_OPEN) begin
      fdepth = depth + 1'b1;
      bdepth = depth - 1'b1;
    end else if (prog_rdata == CMD_CLOSE) begin
      fdepth = depth - 1'b1;
      bdepth = depth + 1'b1;
    end
  end

  assign scan_prev = scan_p - 1'b1;

  always_comb begin
    state_next    = state;
    plen_next     = plen;
    pc_next       = pc;
    tp_next       = tp;
    halt_next     = halt;
    scan_p_next   = scan_p;
    depth_next    = depth;
    clr_addr_next = clr_addr;
    in_byte_next  = in_byte;
    res_q_next    = res_q;
    prog_req      = '0;
    tape_req      = '0;
    item_ready    = 1'b0;
    res_valid     = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        // zero the tape, one cell a cycle
        tape_req.we    = 1'b1;
        tape_req.waddr = clr_addr;
        clr_addr_next  = clr_addr + 1'b1;
        if (clr_addr == TAPE_LAST) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          in_byte_next = item.in_byte;
          res_q_next   = '0;
          state_next   = ST_DONE;
          if (item.mode == MODE_LOAD) begin
            if (plen < PROG_FULL) begin
              prog_req.we    = 1'b1;
              prog_req.waddr = plen[PA_W-1:0];
              prog_req.wdata = item.program_byte;
              plen_next      = plen + 1'b1;
            end
            pc_next   = '0;
            tp_next   = '0;
            halt_next = STATUS_RUN;
          end else if (halt != STATUS_RUN) begin
            state_next = ST_DONE;
          end else if (pc >= plen) begin
            halt_next = STATUS_DONE;
          end else begin
            prog_req.re    = 1'b1;
            prog_req.raddr = pc[PA_W-1:0];
            tape_req.re    = 1'b1;
            tape_req.raddr = tp;
            state_next     = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        state_next = ST_DONE;
        if (prog_rdata == CMD_END) begin
          halt_next = STATUS_DONE;
        end else begin
          pc_next = pc + 1'b1;
          unique case (prog_rdata)
            CMD_RIGHT: tp_next = (tp == TAPE_LAST) ? '0 : tp + 1'b1;
            CMD_LEFT:  tp_next = (tp == '0) ? TAPE_LAST : tp - 1'b1;
            CMD_INC: begin
              tape_req.we    = 1'b1;
              tape_req.waddr = tp;
              tape_req.wdata = tape_rdata + 8'd1;
            end
            CMD_DEC: begin
              tape_req.we    = 1'b1;
              tape_req.waddr = tp;
              tape_req.wdata = tape_rdata - 8'd1;
            end
            CMD_OUT: begin
              res_q_next.out_valid = 1'b1;
              res_q_next.out_byte  = tape_rdata;
            end
            CMD_IN: begin
              res_q_next.took_input = 1'b1;
              tape_req.we           = 1'b1;
              tape_req.waddr        = tp;
              tape_req.wdata        = in_byte;
            end
            CMD_OPEN: begin
              if (tape_rdata == 8'd0) begin
                scan_p_next = pc + 1'b1;
                depth_next  = PL_W'(1);
                state_next  = ST_FSCAN_REQ;
              end
            end
            CMD_CLOSE: begin
              if (tape_rdata != 8'd0) begin
                scan_p_next = pc;
                depth_next  = PL_W'(1);
                state_next  = ST_BSCAN_REQ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_FSCAN_REQ: begin
        if (scan_p >= plen) begin
          halt_next  = STATUS_ERROR;
          state_next = ST_DONE;
        end else begin
          prog_req.re    = 1'b1;
          prog_req.raddr = scan_p[PA_W-1:0];
          state_next     = ST_FSCAN_CHK;
        end
      end

      ST_FSCAN_CHK: begin
        if (prog_rdata == CMD_END) begin
          halt_next  = STATUS_ERROR;
          state_next = ST_DONE;
        end else begin
          depth_next  = fdepth;
          scan_p_next = scan_p + 1'b1;
          if (fdepth == '0) begin
            pc_next    = scan_p + 1'b1;
            state_next = ST_DONE;
          end else begin
            state_next = ST_FSCAN_REQ;
          end
        end
      end

      ST_BSCAN_REQ: begin
        if (scan_p == '0) begin
          halt_next  = STATUS_ERROR;
          state_next = ST_DONE;
        end else begin
          scan_p_next    = scan_prev;
          prog_req.re    = 1'b1;
          prog_req.raddr = scan_prev[PA_W-1:0];
          state_next     = ST_BSCAN_CHK;
        end
      end

      ST_BSCAN_CHK: begin
        depth_next = bdepth;
        if (bdepth == '0) begin
          pc_next    = scan_p;
          state_next = ST_DONE;
        end else begin
          state_next = ST_BSCAN_REQ;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Status always reflects the halt code left by the item
  always_comb begin
    res        = res_q;
    res.status = halt;
  end

  a_pc_bound: assert property (@(posedge clk) disable iff (rst) pc <= plen)
    else $error("program counter beyond program length");

  a_plen_bound: assert property (@(posedge clk) disable iff (rst) plen <= PROG_FULL)
    else $error("program length beyond store depth");

  a_halt_code: assert property (@(posedge clk) disable iff (rst)
      halt == STATUS_RUN || halt == STATUS_DONE || halt == STATUS_ERROR)
    else $error("illegal halt code");

  a_load_rewinds: assert property (@(posedge clk) disable iff (rst)
      (item_valid && item_ready && item.mode == MODE_LOAD)
      |=> (pc == '0 && tp == '0 && halt == STATUS_RUN))
    else $error("load did not rewind execution");

  a_no_write_while_ready: assert property (@(posedge clk) disable iff (rst)
      tape_req.we |-> !item_ready)
    else $error("tape written while taking a new item");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tape machine step block. A short scripted
// program exercises program end, halting, both unmatched bracket errors, cell
// and pointer wrap; random programs built from loops that exit on a zero input
// byte then run repeatedly as the program grows, ending with a zero
// terminator. Every result is checked against the script or a local model.
// ----------------------------------------------------------------------------
module tb;
  import btm_pkg::*;

  localparam int SCRIPT_LEN   = 27;
  localparam int ITEM_TARGET  = 1250;
  localparam int BROKEN_FROM  = 1150;  // lone brackets only late, they block progress
  localparam int HOLD_AT      = 600;
  localparam int LONG_HOLD    = 300;
  localparam int RUN_CAP      = 500;
  localparam int FINAL_CAP    = 80;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam logic TYPED      = 1'b1;
  localparam logic PREDICTED  = 1'b0;

  typedef struct packed {
    item_t   stim;
    logic    typed;
    result_t want;
  } script_row_t;

  // Leaves the program ",][]-.<>+." behind: with a zero fed to the leading
  // comma it always runs through cleanly, so later code can be reached.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    {MODE_STEP, 8'h00,     8'h00, TYPED,     1'b0, 8'h00, 1'b0, STATUS_DONE},  // empty
    {MODE_LOAD, CMD_IN,    8'h00, TYPED,     1'b0, 8'h00, 1'b0, STATUS_RUN},
    {MODE_LOAD, CMD_CLOSE, 8'hFF, TYPED,     1'b0, 8'h00, 1'b0, STATUS_RUN},
    {MODE_STEP, 8'hFF,     8'hFF, TYPED,     1'b0, 8'h00, 1'b1, STATUS_RUN},   // reads FF
    {MODE_STEP, 8'h00,     8'h00, TYPED,     1'b0, 8'h00, 1'b0, STATUS_ERROR}, // no '['
    {MODE_STEP, 8'h00,     8'h00, TYPED,     1'b0, 8'h00, 1'b0, STATUS_ERROR}, // halted
    {MODE_LOAD, CMD_OPEN,  8'h00, TYPED,     1'b0, 8'h00, 1'b0, STATUS_RUN},
    {MODE_STEP, 8'h00,     8'h00, PREDICTED, 1'b0, 8'h00, 1'b0, STATUS_RUN},
    {MODE_STEP, 8'h00,     8'h00, PREDICTED, 1'b0, 8'h00, 1'b0, STATUS_RUN},
    {MODE_STEP, 8'h00,     8'h00, TYPED,     1'b0, 8'h00, 1'b0, STATUS_ERROR}, // no ']'
    {MODE_LOAD, CMD_CLOSE, 8'h00, TYPED,     1'b0, 8'h00, 1'b0, STATUS_RUN},
    {MODE_LOAD, CMD_DEC,   8'h00, TYPED,     1'b0, 8'h00, 1'b0, STATUS_RUN},
    {MODE_LOAD, CMD_OUT,   8'h00, TYPED,     1'b0, 8'h00, 1'b0, STATUS_RUN},
    {MODE_LOAD, CMD_LEFT,  8'h00, TYPED,     1'b0, 8'h00, 1'b0, STATUS_RUN},
    {MODE_LOAD, CMD_RIGHT, 8'h00, TYPED,     1'b0, 8'h00, 1'b0, STATUS_RUN},
    {MODE_LOAD, CMD_INC,   8'h00, TYPED,     1'b0, 8'h00, 1'b0, STATUS_RUN},
    {MODE_LOAD, CMD_OUT,   8'h00, TYPED,     1'b0, 8'h00, 1'b0, STATUS_RUN},
    {MODE_STEP, 8'h00,     8'h00, PREDICTED, 1'b0, 8'h00, 1'b0, STATUS_RUN},
    {MODE_STEP, 8'h00,     8'h00, PREDICTED, 1'b0, 8'h00, 1'b0, STATUS_RUN},
    {MODE_STEP, 8'h00,     8'h00, PREDICTED, 1'b0, 8'h00, 1'b0, STATUS_RUN},   // skip
    {MODE_STEP, 8'h00,     8'h00, PREDICTED, 1'b0, 8'h00, 1'b0, STATUS_RUN},   // 0 - 1
    {MODE_STEP, 8'h00,     8'h00, TYPED,     1'b1, 8'hFF, 1'b0, STATUS_RUN},
    {MODE_STEP, 8'h00,     8'h00, PREDICTED, 1'b0, 8'h00, 1'b0, STATUS_RUN},   // to top
    {MODE_STEP, 8'h00,     8'h00, PREDICTED, 1'b0, 8'h00, 1'b0, STATUS_RUN},   // to 0
    {MODE_STEP, 8'h00,     8'h00, PREDICTED, 1'b0, 8'h00, 1'b0, STATUS_RUN},   // FF + 1
    {MODE_STEP, 8'h00,     8'h00, TYPED,     1'b1, 8'h00, 1'b0, STATUS_RUN},
    {MODE_STEP, 8'h00,     8'h00, TYPED,     1'b0, 8'h00, 1'b0, STATUS_DONE}
  };

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  bracket_tape_machine_step u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Local copy of the machine state
  logic [7:0]      code_mem [PROG_DEPTH];
  logic [PL_W-1:0] code_len = '0;
  logic [PL_W-1:0] code_pc = '0;
  bit   [7:0]      cells [TAPE_DEPTH];
  logic [TA_W-1:0] head = '0;
  logic [1:0]      stop_code = STATUS_RUN;

  result_t awaited_results [$];
  logic [7:0] pending_code [$];

  int  fault_count = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  n_loads = 0, n_steps = 0, n_emits = 0, n_takes = 0, n_bracket_errs = 0, n_ends = 0;
  int  cycle_count = 0;
  bit  sender_quiet = 1'b0;
  bit  hold_wanted = 1'b0;
  int  hold_left = 0;

  function automatic int idle_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit at_prog_end(int p);
    return p >= int'(code_len) || code_mem[p] == CMD_END;
  endfunction

  function automatic result_t interpret_item(item_t it);
    result_t         r;
    logic [7:0]      op;
    logic [TA_W-1:0] tp;
    int              p;
    int              depth;
    r = '0;
    if (it.mode == MODE_LOAD) begin
      n_loads++;
      if (code_len < PROG_FULL) begin
        code_mem[code_len[PA_W-1:0]] = it.program_byte;
        code_len = code_len + 1'b1;
      end
      code_pc = '0;
      head = '0;
      stop_code = STATUS_RUN;
      r.status = STATUS_RUN;
      return r;
    end
    n_steps++;
    if (stop_code != STATUS_RUN) begin
      r.status = stop_code;
      return r;
    end
    if (at_prog_end(int'(code_pc))) begin
      stop_code = STATUS_DONE;
      n_ends++;
      r.status = stop_code;
      return r;
    end
    tp = head;
    op = code_mem[code_pc[PA_W-1:0]];
    code_pc = code_pc + 1'b1;
    // tape size is a power of two, so the pointer wraps on its own width
    case (op)
      CMD_RIGHT: head = tp + 1'b1;
      CMD_LEFT:  head = tp - 1'b1;
      CMD_INC:   cells[tp] = cells[tp] + 8'd1;
      CMD_DEC:   cells[tp] = cells[tp] - 8'd1;
      CMD_OUT: begin
        r.out_valid = 1'b1;
        r.out_byte = cells[tp];
        n_emits++;
      end
      CMD_IN: begin
        r.took_input = 1'b1;
        cells[tp] = it.in_byte;
        n_takes++;
      end
      CMD_OPEN: begin
        if (cells[tp] == 8'd0) begin
          p = int'(code_pc);
          depth = 1;
          while (depth != 0) begin
            if (at_prog_end(p)) begin
              stop_code = STATUS_ERROR;
              break;
            end
            if (code_mem[p] == CMD_OPEN) depth++;
            else if (code_mem[p] == CMD_CLOSE) depth--;
            p++;
          end
          if (stop_code == STATUS_RUN) code_pc = PL_W'(p);
          else n_bracket_errs++;
        end
      end
      CMD_CLOSE: begin
        if (cells[tp] != 8'd0) begin
          p = int'(code_pc) - 1;
          depth = 1;
          while (depth != 0) begin
            if (p == 0) begin
              stop_code = STATUS_ERROR;
              break;
            end
            p--;
            if (code_mem[p] == CMD_CLOSE) depth++;
            else if (code_mem[p] == CMD_OPEN) depth--;
          end
          if (stop_code == STATUS_RUN) code_pc = PL_W'(p);
          else n_bracket_errs++;
        end
      end
      default: ;
    endcase
    r.status = stop_code;
    return r;
  endfunction

  // Work out the result up front, then hold the item until it is taken
  task automatic offer(input item_t it, input logic typed, input result_t want);
    result_t predicted;
    int      gap;
    predicted = interpret_item(it);
    awaited_results.push_back(typed ? want : predicted);
    items_sent++;
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    gap = idle_span();
    if (sender_quiet || hold_wanted || hold_left > 0) gap = 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_byte(input logic [7:0] b);
    offer({MODE_LOAD, b, 8'($urandom_range(0, 255))}, PREDICTED, '0);
  endtask

  task automatic step_once();
    logic [7:0] ib;
    int         roll;
    roll = $urandom_range(0, 99);
    if (code_pc == '0 && stop_code == STATUS_RUN && code_len != '0)
      // the leading comma gates the whole program: feed it a zero nearly always
      ib = (roll < 5) ? 8'($urandom_range(1, 255)) : 8'h00;
    else if (roll < 30)
      ib = 8'h00;
    else if (roll < 40)
      ib = 8'hFF;
    else
      ib = 8'($urandom_range(0, 255));
    offer({MODE_STEP, 8'($urandom_range(0, 255)), ib}, PREDICTED, '0);
  endtask

  task automatic run_until_halt(input int cap);
    for (int k = 0; k < cap && stop_code == STATUS_RUN; k++) step_once();
  endtask

  function automatic logic [7:0] plain_cmd();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 18) return CMD_RIGHT;
    if (roll < 36) return CMD_LEFT;
    if (roll < 52) return CMD_INC;
    if (roll < 66) return CMD_DEC;
    if (roll < 80) return CMD_OUT;
    if (roll < 92) return CMD_IN;
    // any other non-zero byte is a no-op
    do roll = $urandom_range(1, 255);
    while (roll == CMD_RIGHT || roll == CMD_LEFT || roll == CMD_INC || roll == CMD_DEC ||
           roll == CMD_OUT || roll == CMD_IN || roll == CMD_OPEN || roll == CMD_CLOSE);
    return 8'(roll);
  endfunction

  // A loop exits once the comma before its ']' reads a zero
  function automatic void add_flat_loop();
    pending_code.push_back(CMD_OPEN);
    repeat ($urandom_range(1, 3)) pending_code.push_back(plain_cmd());
    pending_code.push_back(CMD_IN);
    pending_code.push_back(CMD_CLOSE);
  endfunction

  function automatic void add_piece(bit allow_broken);
    int roll;
    roll = $urandom_range(0, 99);
    if (allow_broken && roll < 8) begin
      pending_code.push_back(($urandom_range(0, 1) == 0) ? CMD_OPEN : CMD_CLOSE);
    end else if (roll < 68) begin
      pending_code.push_back(plain_cmd());
    end else if (roll < 86) begin
      add_flat_loop();
    end else begin
      pending_code.push_back(CMD_OPEN);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 2) == 0) add_flat_loop();
        else pending_code.push_back(plain_cmd());
      end
      pending_code.push_back(CMD_IN);
      pending_code.push_back(CMD_CLOSE);
    end
  endfunction

  task automatic note_mismatch(input string field, input int want, input int got);
    fault_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("%0t: run stopped after %0d cycles, %0d results outstanding",
             $time, CYCLE_LIMIT, awaited_results.size());
    $display("tb: failure");
    $finish;
  end

  // Result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int      stall_left;
    bit      rx_quiet;
    result_t want;
    stall_left = 0;
    rx_quiet = 1'b0;
    forever begin
      if (hold_left == 0 && hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
      @(posedge clk);
      if (result_valid && result_ready) begin
        results_checked++;
        if (awaited_results.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected result %h with nothing outstanding", $time, result);
        end else begin
          want = awaited_results.pop_front();
          if (result.out_valid != want.out_valid)
            note_mismatch("out_valid", want.out_valid, result.out_valid);
          if (result.out_byte != want.out_byte)
            note_mismatch("out_byte", want.out_byte, result.out_byte);
          if (result.took_input != want.took_input)
            note_mismatch("took_input", want.took_input, result.took_input);
          if (result.status != want.status)
            note_mismatch("status", want.status, result.status);
        end
        if ($urandom_range(0, 49) == 0) rx_quiet = ~rx_quiet;
        if (!rx_quiet) stall_left = idle_span();
      end else if (!rx_quiet && $urandom_range(0, 49) == 0) begin
        stall_left = idle_span();
      end
    end
  end

  // Item side
  initial begin
    bit hold_done;
    int run_len;
    hold_done = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++)
      offer(SCRIPT[i].stim, SCRIPT[i].typed, SCRIPT[i].want);

    // Grow the program a chunk at a time; each load rewinds, so rerun it
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > HOLD_AT && !hold_done) begin
        hold_wanted = 1'b1;
        hold_done = 1'b1;
      end
      repeat ($urandom_range(1, 5)) add_piece(items_sent > BROKEN_FROM);
      while (pending_code.size() > 0) load_byte(pending_code.pop_front());
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : RUN_CAP;
      // keep the run within the item budget
      if (run_len > ITEM_TARGET - items_sent) run_len = ITEM_TARGET - items_sent;
      run_until_halt(run_len);
      repeat ($urandom_range(0, 2)) step_once();
      if ($urandom_range(0, 99) < 30) sender_quiet = ~sender_quiet;
    end

    // Terminate with a zero byte and run up to it
    sender_quiet = 1'b0;
    load_byte(CMD_END);
    run_until_halt(FINAL_CAP);
    repeat (2) step_once();
    item_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: %0d loads and %0d steps, %0d results checked, program length %0d",
             n_loads, n_steps, results_checked, code_len);
    $display("tb: %0d bytes out, %0d bytes in, %0d bracket errors, %0d program ends",
             n_emits, n_takes, n_bracket_errs, n_ends);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== bracket_tape_machine_step.f =====
sv/btm_pkg.sv
sv/btm_ram.sv
sv/btm_seq.sv
sv/bracket_tape_machine_step.sv
tb/tb.sv
